/* sv/rhm_pkg.sv */
// Shared types, constants and helpers for the rolling heartbeat monitor.
// No dependencies; every other file imports this package.
package rhm_pkg;

  localparam int DEFAULT_WINDOW_DEPTH = 1024;

  // Field widths that are fixed by the block's interface.
  localparam int TIME_W      = 32;
  localparam int COUNT_W     = 8;
  localparam int WIN_CFG_W   = 11;
  localparam int THR_W       = 10;
  localparam int FILL_OUT_W  = 11;
  localparam int MSUM_OUT_W  = 18;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam int MIN_ENTRIES    = 2;
  localparam int US_PER_S       = 1000000;
  localparam int US_PER_S_W     = 20;
  localparam int PERMILLE_SCALE = 1000;
  localparam int PERMILLE_W     = 10;

  // Register values after reset.
  localparam logic [WIN_CFG_W-1:0] RST_WINDOW_IN_USE  = 11'd1000;
  localparam logic [THR_W-1:0]     RST_RATE_THR_HZ    = 10'd35;
  localparam logic [THR_W-1:0]     RST_MISS_THR_TENTH = 10'd20;
  localparam logic [TIME_W-1:0]    RST_TIMEOUT_US     = 32'd500000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_IN_USE = 2'd0,
    CFG_RATE_THR_HZ   = 2'd1,
    CFG_MISS_THR      = 2'd2,
    CFG_TIMEOUT_US    = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    LVL_OK   = 2'd0,
    LVL_WARN = 2'd1,
    LVL_ERR  = 2'd2
  } level_t;

  typedef enum logic [2:0] {
    RSN_OK        = 3'd0,
    RSN_NONE      = 3'd1,
    RSN_DUPLICATE = 3'd2,
    RSN_RATE_LOW  = 3'd3,
    RSN_MISS_ERR  = 3'd4,
    RSN_MISS_WARN = 3'd5,
    RSN_TIMEOUT   = 3'd6
  } reason_t;

  localparam logic FUNC_BEAT  = 1'b0;
  localparam logic FUNC_CHECK = 1'b1;

  // One ring entry.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  stamp;
  } entry_t;

  // What the front end captures for a status check.
  typedef struct packed {
    logic               too_few;
    logic               dup;
    logic               tmo;
    logic [COUNT_W-1:0] latest;
    logic [TIME_W-1:0]  elapsed;
    logic [TIME_W-1:0]  dt;
  } snap_t;

  // Number of counts skipped between adjacent heartbeats, modulo 256.
  function automatic logic [COUNT_W-1:0] beat_gap(input logic [COUNT_W-1:0] c,
                                                  input logic [COUNT_W-1:0] n);
    logic [COUNT_W-1:0] g;
    g = n - c - COUNT_W'(1);
    if (c == n) begin
      g = '0;
    end
    return g;
  endfunction

endpackage

/* sv/rhm_in_if.sv */
// Input channel of the heartbeat monitor: heartbeat or check transactions.
// Depends on rhm_pkg for field widths.
interface rhm_in_if import rhm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [TIME_W-1:0]  time_us;
  logic [COUNT_W-1:0] beat_count;

  modport source (output valid, output func, output time_us, output beat_count,
                  input ready);
  modport sink (input valid, input func, input time_us, input beat_count,
                output ready);
endinterface

/* sv/rhm_out_if.sv */
// Result channel of the heartbeat monitor: one status per check.
// Depends on rhm_pkg for field widths.
interface rhm_out_if import rhm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            status_level;
  logic [2:0]            reason_code;
  logic [COUNT_W-1:0]    latest_count;
  logic [TIME_W-1:0]     elapsed_us;
  logic [MSUM_OUT_W-1:0] missing_total;
  logic [FILL_OUT_W-1:0] window_fill;

  modport source (output valid, output status_level, output reason_code,
                  output latest_count, output elapsed_us, output missing_total,
                  output window_fill, input ready);
  modport sink (input valid, input status_level, input reason_code,
                input latest_count, input elapsed_us, input missing_total,
                input window_fill, output ready);
endinterface

/* sv/rhm_cfg_if.sv */
// Configuration write channel of the heartbeat monitor.
// Depends on rhm_pkg for field widths.
interface rhm_cfg_if import rhm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/rhm_check.sv */
// Status check pipeline: products, comparisons and the output register.
// Depends on rhm_pkg and rhm_out_if.
module rhm_check import rhm_pkg::*; #(
  parameter int FILL_W = 11,
  parameter int MSUM_W = 18
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              snap_valid,
  input  snap_t             snap,
  input  logic [FILL_W-1:0] snap_fill,
  input  logic [MSUM_W-1:0] snap_msum,
  input  logic [THR_W-1:0]  rate_thr,
  input  logic [THR_W-1:0]  miss_thr,
  output logic              take_ok,
  rhm_out_if.source         out_chan
);

  localparam int RATE_L_W = FILL_W + US_PER_S_W;
  localparam int RATE_R_W = THR_W + TIME_W;
  localparam int MISS_L_W = MSUM_W + PERMILLE_W;
  localparam int MISS_R_W = THR_W + FILL_W;

  // Stage 1: captured snapshot.
  logic              v1_r;
  snap_t             snap1_r;
  logic [FILL_W-1:0] fill1_r;
  logic [MSUM_W-1:0] msum1_r;

  // Stage 2: registered products.
  logic                v2_r;
  snap_t               snap2_r;
  logic [FILL_W-1:0]   fill2_r;
  logic [MSUM_W-1:0]   msum2_r;
  logic [RATE_L_W-1:0] rate_lhs_r;
  logic [RATE_R_W-1:0] rate_rhs_r;
  logic [MISS_L_W-1:0] miss_lhs_r;
  logic [MISS_R_W-1:0] miss_rhs_r;

  // Output register.
  logic              out_valid_r;
  level_t            level_r;
  reason_t           reason_r;
  logic [COUNT_W-1:0] latest_r;
  logic [TIME_W-1:0] elapsed_r;
  logic [MSUM_W-1:0] msum_out_r;
  logic [FILL_W-1:0] fill_out_r;

  logic    out_free;
  logic    s2_free;
  logic    s1_free;
  logic    rate_low;
  logic    miss_err;
  logic    any_err;
  level_t  level_nxt;
  reason_t reason_nxt;

  assign out_free = !out_valid_r || out_chan.ready;
  assign s2_free  = !v2_r || out_free;
  assign s1_free  = !v1_r || s2_free;
  assign take_ok  = s1_free;

  always_comb begin
    rate_low = (snap2_r.dt != '0) && (64'(rate_lhs_r) < 64'(rate_rhs_r));
    miss_err = 64'(miss_lhs_r) > 64'(miss_rhs_r);
    any_err    = 1'b0;
    level_nxt  = LVL_OK;
    reason_nxt = RSN_OK;
    if (snap2_r.too_few) begin
      level_nxt  = LVL_ERR;
      reason_nxt = RSN_NONE;
    end else begin
      if (snap2_r.dup) begin
        level_nxt  = LVL_ERR;
        reason_nxt = RSN_DUPLICATE;
        any_err    = 1'b1;
      end
      if (rate_low) begin
        level_nxt  = LVL_ERR;
        reason_nxt = RSN_RATE_LOW;
        any_err    = 1'b1;
      end
      if (miss_err) begin
        level_nxt  = LVL_ERR;
        reason_nxt = RSN_MISS_ERR;
      end else if ((msum2_r != '0) && !any_err) begin
        level_nxt  = LVL_WARN;
        reason_nxt = RSN_MISS_WARN;
      end
      if (snap2_r.tmo) begin
        level_nxt  = LVL_ERR;
        reason_nxt = RSN_TIMEOUT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free) begin
        v1_r <= snap_valid;
      end
      if (s2_free) begin
        v2_r <= v1_r;
      end
      if (out_free) begin
        out_valid_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && snap_valid) begin
      snap1_r <= snap;
      fill1_r <= snap_fill;
      msum1_r <= snap_msum;
    end
    if (s2_free && v1_r) begin
      snap2_r    <= snap1_r;
      fill2_r    <= fill1_r;
      msum2_r    <= msum1_r;
      rate_lhs_r <= RATE_L_W'(fill1_r) * RATE_L_W'(US_PER_S);
      rate_rhs_r <= RATE_R_W'(rate_thr) * RATE_R_W'(snap1_r.dt);
      miss_lhs_r <= MISS_L_W'(msum1_r) * MISS_L_W'(PERMILLE_SCALE);
      miss_rhs_r <= MISS_R_W'(miss_thr) * MISS_R_W'(fill1_r);
    end
    if (out_free && v2_r) begin
      level_r    <= level_nxt;
      reason_r   <= reason_nxt;
      latest_r   <= snap2_r.latest;
      elapsed_r  <= snap2_r.elapsed;
      msum_out_r <= msum2_r;
      fill_out_r <= fill2_r;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status_level  = level_r;
  assign out_chan.reason_code   = reason_r;
  assign out_chan.latest_count  = latest_r;
  assign out_chan.elapsed_us    = elapsed_r;
  assign out_chan.missing_total = MSUM_OUT_W'(msum_out_r);
  assign out_chan.window_fill   = FILL_OUT_W'(fill_out_r);

endmodule

/* sv/rolling_heartbeat_monitor.sv */
// Top level of the rolling heartbeat monitor: window ring memory and state.
// Depends on rhm_pkg, rhm_in_if, rhm_out_if, rhm_cfg_if and rhm_check.
//
// Usage. The input channel carries two kinds of transaction. A heartbeat
// (func 0) appends its beat_count and time_us to a sliding window ring and
// produces no result. A check (func 1) carries the current time and produces
// exactly one status transaction on the output channel. The configuration
// channel writes the four registers and is always ready; it must only be used
// while no check is in flight.
// Throughput is one transaction per cycle while the check pipeline has room.
// The one exception is a heartbeat that drops the oldest window entry: the
// ring memory is read for the new oldest entry as the heartbeat is accepted,
// and input ready is then low for a single cycle while that entry is taken in.
// A check's status passes the stage 1, stage 2 and output registers in turn.
// Reset clears the window to empty and loads the register defaults; the ring
// contents are not cleared and no clearing pass is needed, since only held
// entries are ever read. When the receiver stalls, results wait in a three
// deep pipeline ending in the output register; input stays ready while that
// pipeline has room, and stalls once it is full.
module rolling_heartbeat_monitor import rhm_pkg::*; #(
  parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  rhm_in_if.sink    in_chan,
  rhm_out_if.source out_chan,
  rhm_cfg_if.sink   cfg_chan
);

  localparam int ADDR_W = $clog2(WINDOW_DEPTH);
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int MSUM_W = $clog2(WINDOW_DEPTH * 255 + 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WINDOW_DEPTH - 1);

  // Configuration registers.
  logic [WIN_CFG_W-1:0] win_r;
  logic [THR_W-1:0]     rate_thr_r;
  logic [THR_W-1:0]     miss_thr_r;
  logic [TIME_W-1:0]    timeout_r;

  // Window bookkeeping.
  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [MSUM_W-1:0] msum_r, msum_nxt;
  logic              pend_r, pend_nxt;

  // Newest and oldest entries and the second newest count are mirrored in registers
  // so a check never has to touch the ring.
  logic [COUNT_W-1:0] newest_count_r, newest_count_nxt;
  logic [TIME_W-1:0]  newest_stamp_r, newest_stamp_nxt;
  logic [COUNT_W-1:0] prev_count_r, prev_count_nxt;
  logic [COUNT_W-1:0] oldest_count_r, oldest_count_nxt;
  logic [TIME_W-1:0]  oldest_stamp_r, oldest_stamp_nxt;

  // Ring memory with one write and one registered read port.
  entry_t            ring_mem [WINDOW_DEPTH];
  entry_t            rd_entry_r;
  logic              mem_wr;
  logic [ADDR_W-1:0] mem_wr_addr;
  logic              mem_rd;
  logic [ADDR_W-1:0] mem_rd_addr;

  logic              take_ok;
  logic              in_acc;
  logic              beat_acc;
  logic              check_acc;
  logic [FILL_W-1:0] win_eff;
  logic              pop;
  logic [ADDR_W-1:0] head_inc;
  logic [ADDR_W-1:0] head_after;
  logic [FILL_W-1:0] fill_after;
  logic [FILL_W:0]   tail_sum;
  logic [ADDR_W-1:0] tail_addr;
  logic [TIME_W-1:0] elapsed;
  logic              too_few;
  logic              tmo;
  snap_t             snap;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r      <= RST_WINDOW_IN_USE;
      rate_thr_r <= RST_RATE_THR_HZ;
      miss_thr_r <= RST_MISS_THR_TENTH;
      timeout_r  <= RST_TIMEOUT_US;
    end else if (cfg_chan.valid) begin
      case (cfg_reg_t'(cfg_chan.index))
        CFG_WINDOW_IN_USE: win_r      <= cfg_chan.data[WIN_CFG_W-1:0];
        CFG_RATE_THR_HZ:   rate_thr_r <= cfg_chan.data[THR_W-1:0];
        CFG_MISS_THR:      miss_thr_r <= cfg_chan.data[THR_W-1:0];
        CFG_TIMEOUT_US:    timeout_r  <= cfg_chan.data[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // While a drop's memory read is outstanding the oldest entry and the gap
  // sum are stale, so the input is held off for that cycle.
  assign in_chan.ready = !pend_r && take_ok;
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign beat_acc      = in_acc && (in_chan.func == FUNC_BEAT);
  assign check_acc     = in_acc && (in_chan.func == FUNC_CHECK);

  // The window register is clamped to the range the ring can hold.
  always_comb begin
    win_eff = FILL_W'(win_r);
    if (win_r < WIN_CFG_W'(MIN_ENTRIES)) begin
      win_eff = FILL_W'(MIN_ENTRIES);
    end else if (32'(win_r) > 32'(WINDOW_DEPTH)) begin
      win_eff = FILL_W'(WINDOW_DEPTH);
    end
  end

  assign pop        = fill_r >= win_eff;
  assign head_inc   = (head_r == LAST_ADDR) ? '0 : head_r + ADDR_W'(1);
  assign head_after = pop ? head_inc : head_r;
  assign fill_after = fill_r - FILL_W'(pop);

  always_comb begin
    tail_sum = (FILL_W + 1)'(head_after) + (FILL_W + 1)'(fill_after);
    if (tail_sum >= (FILL_W + 1)'(WINDOW_DEPTH)) begin
      tail_sum = tail_sum - (FILL_W + 1)'(WINDOW_DEPTH);
    end
    tail_addr = ADDR_W'(tail_sum);
  end

  assign mem_wr      = beat_acc;
  assign mem_wr_addr = tail_addr;
  assign mem_rd      = beat_acc && pop;
  assign mem_rd_addr = head_inc;

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      ring_mem[mem_wr_addr] <= '{count: in_chan.beat_count, stamp: in_chan.time_us};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      rd_entry_r <= ring_mem[mem_rd_addr];
    end
  end

  // Check front end: the window is judged as it stands when the check is
  // accepted. Only the timeout test changes state, so it is decided here.
  assign too_few = fill_r < FILL_W'(MIN_ENTRIES);
  assign elapsed = in_chan.time_us - newest_stamp_r;
  assign tmo     = !too_few && (elapsed > timeout_r);

  always_comb begin
    snap.too_few = too_few;
    snap.dup     = newest_count_r == prev_count_r;
    snap.tmo     = tmo;
    snap.latest  = too_few ? '0 : newest_count_r;
    snap.elapsed = too_few ? '0 : elapsed;
    snap.dt      = newest_stamp_r - oldest_stamp_r;
  end

  always_comb begin
    head_nxt         = head_r;
    fill_nxt         = fill_r;
    msum_nxt         = msum_r;
    pend_nxt         = 1'b0;
    newest_count_nxt = newest_count_r;
    newest_stamp_nxt = newest_stamp_r;
    prev_count_nxt   = prev_count_r;
    oldest_count_nxt = oldest_count_r;
    oldest_stamp_nxt = oldest_stamp_r;

    if (pend_r) begin
      // Second half of a drop: the entry after the old head is now the
      // oldest, and the gap leading into it leaves the sum.
      msum_nxt = msum_r - MSUM_W'(beat_gap(oldest_count_r, rd_entry_r.count));
      oldest_count_nxt = rd_entry_r.count;
      oldest_stamp_nxt = rd_entry_r.stamp;
    end

    if (beat_acc) begin
      head_nxt = head_after;
      fill_nxt = fill_after + FILL_W'(1);
      pend_nxt = pop;
      if (fill_r != '0) begin
        msum_nxt = msum_r + MSUM_W'(beat_gap(newest_count_r, in_chan.beat_count));
      end else begin
        oldest_count_nxt = in_chan.beat_count;
        oldest_stamp_nxt = in_chan.time_us;
      end
      prev_count_nxt   = newest_count_r;
      newest_count_nxt = in_chan.beat_count;
      newest_stamp_nxt = in_chan.time_us;
    end else if (check_acc && tmo) begin
      // A timeout empties the window after the status is captured.
      head_nxt = '0;
      fill_nxt = '0;
      msum_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
      msum_r <= '0;
      pend_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
      msum_r <= msum_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    newest_count_r <= newest_count_nxt;
    newest_stamp_r <= newest_stamp_nxt;
    prev_count_r   <= prev_count_nxt;
    oldest_count_r <= oldest_count_nxt;
    oldest_stamp_r <= oldest_stamp_nxt;
  end

  rhm_check #(
    .FILL_W (FILL_W),
    .MSUM_W (MSUM_W)
  ) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (check_acc),
    .snap       (snap),
    .snap_fill  (fill_r),
    .snap_msum  (msum_r),
    .rate_thr   (rate_thr_r),
    .miss_thr   (miss_thr_r),
    .take_ok    (take_ok),
    .out_chan   (out_chan)
  );

endmodule

/* dv/rhm_status_checker.sv */
// Status checker for the rolling heartbeat monitor: watches all three channels,
// predicts each check's status from a private copy of the window and registers.
// Depends on rhm_pkg and the rhm_in_if, rhm_out_if and rhm_cfg_if interfaces.
module rhm_status_checker import rhm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rhm_in_if           in_mon,
  rhm_out_if          out_mon,
  rhm_cfg_if          cfg_mon,
  output int unsigned fail_count,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RING_DEPTH = DEFAULT_WINDOW_DEPTH;
  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    level_t                level;
    reason_t               reason;
    logic [COUNT_W-1:0]    latest;
    logic [TIME_W-1:0]     elapsed;
    logic [MSUM_OUT_W-1:0] missing;
    logic [FILL_OUT_W-1:0] fill;
  } status_t;

  // Register copies.
  logic [WIN_CFG_W-1:0] win_reg;
  logic [THR_W-1:0]     rate_thr;
  logic [THR_W-1:0]     miss_thr;
  logic [TIME_W-1:0]    tmo_reg;

  // Window copy.
  logic [COUNT_W-1:0] ring_count [RING_DEPTH];
  logic [TIME_W-1:0]  ring_stamp [RING_DEPTH];
  int unsigned        oldest;
  int unsigned        held;
  int unsigned        gap_sum;

  status_t     expected_status[$];
  int unsigned fails;

  function automatic int unsigned slot(input int unsigned base, input int unsigned off);
    return (base + off) % RING_DEPTH;
  endfunction

  // Counts lost between two adjacent heartbeats; equal counts lose none.
  function automatic int unsigned skipped(input logic [COUNT_W-1:0] c,
                                          input logic [COUNT_W-1:0] n);
    logic [COUNT_W-1:0] d;
    d = n - c - COUNT_W'(1);
    return (c == n) ? 0 : int'(d);
  endfunction

  function automatic void record_beat(input logic [COUNT_W-1:0] cnt,
                                      input logic [TIME_W-1:0] stamp);
    int unsigned span;
    int unsigned tail;
    span = (win_reg < MIN_ENTRIES) ? MIN_ENTRIES : int'(win_reg);
    if (span > RING_DEPTH) span = RING_DEPTH;
    // A full window loses exactly one oldest entry per heartbeat.
    if (held >= span) begin
      gap_sum = gap_sum - skipped(ring_count[oldest], ring_count[slot(oldest, 1)]);
      oldest  = slot(oldest, 1);
      held    = held - 1;
    end
    if (held > 0) gap_sum = gap_sum + skipped(ring_count[slot(oldest, held - 1)], cnt);
    tail = slot(oldest, held);
    ring_count[tail] = cnt;
    ring_stamp[tail] = stamp;
    held = held + 1;
  endfunction

  function automatic status_t predict_status(input logic [TIME_W-1:0] now);
    status_t           s;
    int unsigned       newest;
    int unsigned       prev;
    logic [TIME_W-1:0] span;
    logic              raised;
    s.level   = LVL_OK;
    s.reason  = RSN_OK;
    s.latest  = '0;
    s.elapsed = '0;
    s.missing = MSUM_OUT_W'(gap_sum);
    s.fill    = FILL_OUT_W'(held);
    if (held < MIN_ENTRIES) begin
      s.level  = LVL_ERR;
      s.reason = RSN_NONE;
      return s;
    end
    newest    = slot(oldest, held - 1);
    prev      = slot(oldest, held - 2);
    span      = ring_stamp[newest] - ring_stamp[oldest];
    raised    = 1'b0;
    s.latest  = ring_count[newest];
    s.elapsed = now - ring_stamp[newest];
    if (ring_count[newest] == ring_count[prev]) begin
      s.level  = LVL_ERR;
      s.reason = RSN_DUPLICATE;
      raised   = 1'b1;
    end
    if (span != '0 && 64'(held) * 64'(US_PER_S) < 64'(rate_thr) * 64'(span)) begin
      s.level  = LVL_ERR;
      s.reason = RSN_RATE_LOW;
      raised   = 1'b1;
    end
    if (64'(gap_sum) * 64'(PERMILLE_SCALE) > 64'(miss_thr) * 64'(held)) begin
      s.level  = LVL_ERR;
      s.reason = RSN_MISS_ERR;
    end else if (gap_sum != 0 && !raised) begin
      s.level  = LVL_WARN;
      s.reason = RSN_MISS_WARN;
    end
    // A timeout reports the window as it stood, then empties it.
    if (s.elapsed > tmo_reg) begin
      s.level  = LVL_ERR;
      s.reason = RSN_TIMEOUT;
      oldest   = 0;
      held     = 0;
      gap_sum  = 0;
    end
    return s;
  endfunction

  always @(posedge clk) begin
    status_t want;
    if (!rst_n) begin
      win_reg  = RST_WINDOW_IN_USE;
      rate_thr = RST_RATE_THR_HZ;
      miss_thr = RST_MISS_THR_TENTH;
      tmo_reg  = RST_TIMEOUT_US;
      oldest   = 0;
      held     = 0;
      gap_sum  = 0;
      fails    = 0;
      expected_status.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_status.size() == 0) begin
          fails = fails + 1;
          if (fails <= REPORT_MAX)
            $display("%t checker: status transaction with no check outstanding", $realtime);
        end else begin
          want = expected_status[0];
          expected_status.delete(0);
          if (out_mon.status_level !== want.level || out_mon.reason_code !== want.reason ||
              out_mon.latest_count !== want.latest || out_mon.elapsed_us !== want.elapsed ||
              out_mon.missing_total !== want.missing || out_mon.window_fill !== want.fill)
          begin
            fails = fails + 1;
            if (fails <= REPORT_MAX) begin
              $display("%t checker: status mismatch", $realtime);
              $display("  expected level %0d reason %0d count %0d elapsed %0d missing %0d fill %0d",
                       want.level, want.reason, want.latest, want.elapsed, want.missing,
                       want.fill);
              $display("  actual   level %0d reason %0d count %0d elapsed %0d missing %0d fill %0d",
                       out_mon.status_level, out_mon.reason_code, out_mon.latest_count,
                       out_mon.elapsed_us, out_mon.missing_total, out_mon.window_fill);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.func == FUNC_CHECK) begin
          expected_status.insert(expected_status.size(), predict_status(in_mon.time_us));
        end else begin
          record_beat(in_mon.beat_count, in_mon.time_us);
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_reg_t'(cfg_mon.index))
          CFG_WINDOW_IN_USE: win_reg  = cfg_mon.data[WIN_CFG_W-1:0];
          CFG_RATE_THR_HZ:   rate_thr = cfg_mon.data[THR_W-1:0];
          CFG_MISS_THR:      miss_thr = cfg_mon.data[THR_W-1:0];
          CFG_TIMEOUT_US:    tmo_reg  = cfg_mon.data[TIME_W-1:0];
          default: ;
        endcase
      end
    end
    fail_count <= fails;
    pending    <= expected_status.size();
  end

endmodule

/* dv/testbench.sv */
// Top of the rolling heartbeat monitor testbench: clock, reset, stimulus, verdict.
// Depends on rhm_pkg, the three channel interfaces, rolling_heartbeat_monitor
// and rhm_status_checker.
module testbench import rhm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RESET_CYCLES    = 10;
  // Settle time after the last status: covers a check still passing the check
  // pipeline and a heartbeat that drops the oldest entry still being absorbed.
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned IDLE_LIMIT      = 2000;
  localparam int unsigned N_PHASES        = 10;
  localparam int unsigned PHASE_ITEMS     = 10;
  // Long enough to push more than a full ring of heartbeats through the
  // window, so the oversized window setting is seen to clamp.
  localparam int unsigned BIG_PHASE_ITEMS = 1060;
  localparam logic [TIME_W-1:0] TIME_MAX  = '1;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned pending;

  // Idling controls, changed between phases by the stimulus process.
  int unsigned src_gap_pct    = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned stall_left     = 0;
  int unsigned quiet_cycles   = 0;

  // Stimulus bookkeeping: the heartbeat source's clock and last beat.
  logic [TIME_W-1:0]  t_now;
  logic [TIME_W-1:0]  last_stamp;
  logic [TIME_W-1:0]  tmo_val;
  logic [COUNT_W-1:0] last_beat;
  int unsigned        period;
  int unsigned        check_pct;

  rhm_in_if  in_chan();
  rhm_out_if out_chan();
  rhm_cfg_if cfg_chan();

  rolling_heartbeat_monitor uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  rhm_status_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .cfg_mon    (cfg_chan),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap and stall lengths: usually short, and one time in ten a long one.
  function automatic int unsigned gap_len();
    return ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(3, 1);
  endfunction

  // The result side stalls at random. A stall is chosen at a clock edge, which
  // lowers the registered ready, and its length is drawn from gap_len().
  always @(posedge clk) begin
    if (stall_left > 1) begin
      stall_left     <= stall_left - 1;
      out_chan.ready <= 1'b0;
    end else if ($urandom_range(99) < sink_stall_pct) begin
      stall_left     <= gap_len();
      out_chan.ready <= 1'b0;
    end else begin
      stall_left     <= 0;
      out_chan.ready <= 1'b1;
    end
  end

  // Watchdog: the run is stuck if no channel moves a transaction for a long
  // time. Any legal stall or gap is far shorter than the limit.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("[rolling_heartbeat_monitor] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one input transaction and hold it until the block takes it. The
  // valid stays high afterwards, so back-to-back transactions need no extra
  // assignment; a gap lowers it in the same step the last one was taken.
  task automatic push_item(input logic func, input logic [TIME_W-1:0] t,
                           input logic [COUNT_W-1:0] cnt);
    int unsigned g;
    if ($urandom_range(99) < src_gap_pct) begin
      g = gap_len();
      in_chan.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.func       <= func;
    in_chan.time_us    <= t;
    in_chan.beat_count <= cnt;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // Stop sending and wait until every outstanding status has come back. The
  // first edge lets the checker's count catch up with the last transaction.
  // The settle time covers a heartbeat still being absorbed.
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= value;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
  endtask

  // All four registers, back to back, with the block idle.
  task automatic configure(input logic [CFG_DATA_W-1:0] win, input logic [CFG_DATA_W-1:0] rate,
                           input logic [CFG_DATA_W-1:0] miss, input logic [CFG_DATA_W-1:0] tmo);
    write_reg(CFG_WINDOW_IN_USE, win);
    write_reg(CFG_RATE_THR_HZ, rate);
    write_reg(CFG_MISS_THR, miss);
    write_reg(CFG_TIMEOUT_US, tmo);
    cfg_chan.valid <= 1'b0;
  endtask

  // A heartbeat from a well-behaved source: the count mostly advances by
  // one, sometimes skips a few, repeats, or jumps anywhere. Arrival times
  // jitter around the phase's period and wrap freely.
  task automatic send_beat();
    int unsigned        r;
    logic [COUNT_W-1:0] cnt;
    r = $urandom_range(99);
    if (r < 84) cnt = last_beat + COUNT_W'(1);
    else if (r < 91) cnt = last_beat + COUNT_W'(1 + $urandom_range(12, 1));
    else if (r < 95) cnt = last_beat;
    else cnt = COUNT_W'($urandom);
    t_now = t_now + period / 2 + $urandom_range(period);
    push_item(FUNC_BEAT, t_now, cnt);
    last_beat  = cnt;
    last_stamp = t_now;
  endtask

  // A status check some time after the last heartbeat. Offsets land within
  // two periods, exactly on the timeout, one past it, anywhere, or at zero.
  task automatic send_check();
    int unsigned       r;
    logic [TIME_W-1:0] ofs;
    r = $urandom_range(99);
    if (r < 75) ofs = $urandom_range(2 * period);
    else if (r < 83) ofs = tmo_val;
    else if (r < 88) ofs = tmo_val + 1;
    else if (r < 93) ofs = $urandom;
    else ofs = '0;
    push_item(FUNC_CHECK, last_stamp + ofs, COUNT_W'($urandom));
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] win;
    logic [CFG_DATA_W-1:0] rate;
    logic [CFG_DATA_W-1:0] miss;
    int unsigned           items;

    // The block's inputs are set at time zero, except the result side's
    // ready, which the stall process drives from the first edge on, and reset
    // is held low before it is released.
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.func       <= FUNC_BEAT;
    in_chan.time_us    <= '0;
    in_chan.beat_count <= '0;
    cfg_chan.valid     <= 1'b0;
    cfg_chan.index     <= CFG_WINDOW_IN_USE;
    cfg_chan.data      <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset register values (window 1000, 35 Hz, 2.0 percent,
    // 500 ms timeout), no idling on either side.
    push_item(FUNC_CHECK, 32'd0, 8'd0);               // empty window
    push_item(FUNC_BEAT, 32'd0, 8'd255);
    push_item(FUNC_CHECK, 32'd100, 8'd255);           // a single entry is too few
    push_item(FUNC_BEAT, 32'd40000, 8'd0);            // count wraps, nothing missed
    push_item(FUNC_CHECK, 32'd40010, 8'd0);           // healthy
    push_item(FUNC_BEAT, 32'd80000, 8'd0);
    push_item(FUNC_CHECK, 32'd80000, 8'd0);           // repeated count, zero elapsed
    push_item(FUNC_BEAT, 32'd120000, 8'd3);           // two counts lost
    push_item(FUNC_CHECK, 32'd120500, 8'd0);          // missing above threshold
    push_item(FUNC_BEAT, TIME_MAX, 8'd4);             // stamp at the top of the range
    push_item(FUNC_CHECK, 32'd15, 8'd0);              // time wrapped, huge span: rate low, outranked by missing
    push_item(FUNC_CHECK, TIME_MAX + 32'd500001, 8'd0); // one past the timeout
    push_item(FUNC_CHECK, 32'h0000_1000, 8'd0);       // window was emptied
    push_item(FUNC_BEAT, 32'h8000_0000, 8'd128);
    push_item(FUNC_BEAT, 32'h8000_0000, 8'd129);      // zero span never reads as slow
    push_item(FUNC_CHECK, 32'h8000_0000 + 32'd500000, 8'd255); // exactly at the timeout
    push_item(FUNC_BEAT, 32'h8000_0010, 8'd255);
    push_item(FUNC_CHECK, 32'h8000_0020, 8'd255);
    drain();

    // Random phases. Each one starts idle, rewrites every register and then
    // runs a stream of heartbeats and checks matched to the rate threshold,
    // so rate, missing and timeout tests fall on both sides of their limits.
    for (int p = 0; p < N_PHASES; p++) begin
      rate = ($urandom_range(1) != 0) ? $urandom_range(1023) : $urandom_range(60);
      miss = ($urandom_range(1) != 0) ? $urandom_range(1023) : $urandom_range(60);
      win  = $urandom_range(16, 2);
      case (p)
        0: begin
          win  = 0;                  // below the minimum, acts as two
          rate = 0;
          miss = 1023;
        end
        1: begin
          win  = 1;
          rate = 1023;
          miss = 0;
        end
        2: win = 2047;               // above the ring depth, acts as the depth
        3: win = 3;                  // shrunk while the ring is full
        4: win = 1024;
        5: win = 2;
        default: ;
      endcase
      if (rate == 0) period = $urandom_range(100000, 1000);
      else period = (1000000 / rate) * $urandom_range(150, 50) / 100 + 1;
      case ($urandom_range(9))
        0: tmo_val = '0;
        1: tmo_val = TIME_MAX;
        default: tmo_val = period * $urandom_range(4, 1);
      endcase
      if (p == 1) tmo_val = '0;
      // The long phase and the one after it must not lose the window to a
      // timeout, or the full ring would never be seen.
      if (p == 0 || p == 2 || p == 3) tmo_val = TIME_MAX;
      configure(win, rate, miss, tmo_val);

      if (p % 3 == 1) begin
        src_gap_pct    = 0;
        sink_stall_pct = 0;
      end else begin
        src_gap_pct    = $urandom_range(40, 5);
        sink_stall_pct = $urandom_range(40, 5);
      end
      check_pct  = (p == 2) ? 0 : $urandom_range(50, 20);
      items      = (p == 2) ? BIG_PHASE_ITEMS : PHASE_ITEMS;
      t_now      = $urandom;
      last_stamp = t_now;
      last_beat  = COUNT_W'($urandom);

      for (int i = 0; i < items; i++) begin
        if ($urandom_range(99) < 2) begin
          // Noise: a transaction of any kind with any content.
          push_item(1'($urandom), $urandom, COUNT_W'($urandom));
        end else if ($urandom_range(99) < check_pct) begin
          send_check();
        end else begin
          send_beat();
        end
        // Now and then the source holds off until the block has answered
        // everything it was asked.
        if ($urandom_range(199) == 0) drain();
      end
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("[rolling_heartbeat_monitor] OK");
    end else begin
      $display("[rolling_heartbeat_monitor] ERROR");
    end
    $finish;
  end

endmodule
